// ===== rtl/b58d_pkg.sv =====
// Shared types, codes and character helpers for the Base58 string decoder.
// No dependencies; imported by the accumulator cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package b58d_pkg;

  // Widths fixed by the string length limit (at most 64 characters)
  localparam int CNT_W   = 7;
  localparam int DIG_W   = 6;
  localparam int CARRY_W = 6;
  localparam int PROD_W  = 14;

  localparam logic [PROD_W-1:0] RADIX = 14'd58;
  localparam logic [7:0]        CH_ONE = 8'h31;

  // Scan phase codes
  localparam logic [1:0] PH_LEAD  = 2'd0;
  localparam logic [1:0] PH_ONES  = 2'd1;
  localparam logic [1:0] PH_DIG   = 2'd2;
  localparam logic [1:0] PH_TRAIL = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_TRAIL    = 2'd2;
  localparam logic [1:0] ST_LONG     = 2'd3;

  typedef enum logic [2:0] {
    CM_HOLD,
    CM_MUL,
    CM_RIPPLE,
    CM_SHIFT,
    CM_CLEAR
  } cell_mode_t;

  function automatic logic is_blank(input logic [7:0] c);
    logic r;
    case (c) inside
      [8'd9:8'd13], 8'd32: r = 1'b1;
      default:             r = 1'b0;
    endcase
    return r;
  endfunction

  // Returns {valid, digit}
  function automatic logic [DIG_W:0] digit_of(input logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    ok = 1'b1;
    case (c) inside
      [8'h31:8'h39]: v = c - 8'h31;
      [8'h41:8'h48]: v = c - 8'h41 + 8'd9;
      [8'h4A:8'h4E]: v = c - 8'h4A + 8'd17;
      [8'h50:8'h5A]: v = c - 8'h50 + 8'd22;
      [8'h61:8'h6B]: v = c - 8'h61 + 8'd33;
      [8'h6D:8'h7A]: v = c - 8'h6D + 8'd44;
      default: begin
        v  = 8'd0;
        ok = 1'b0;
      end
    endcase
    return {ok, v[DIG_W-1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/b58d_cell.sv =====
// One byte of the base-256 accumulator with its pending carry.
// Depends on b58d_pkg for the cell mode type and widths.
`timescale 1ns / 1ps
`default_nettype none

module b58d_cell
  import b58d_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cell_mode_t         mode,
  input  wire logic [DIG_W-1:0]   digit_in,   // nonzero only at the least significant cell
  input  wire logic [CARRY_W-1:0] carry_in,   // from the less significant neighbor
  input  wire logic [7:0]         shift_in,   // from the less significant neighbor
  output logic [7:0]              byte_out,
  output logic [CARRY_W-1:0]      carry_out
);

  logic [7:0]         byte_r, byte_nxt;
  logic [CARRY_W-1:0] carry_r, carry_nxt;
  logic [PROD_W-1:0]  prod;

  always_comb begin
    prod      = '0;
    byte_nxt  = byte_r;
    carry_nxt = carry_r;
    case (mode)
      CM_MUL: begin
        prod      = PROD_W'(byte_r) * RADIX + PROD_W'(digit_in);
        byte_nxt  = prod[7:0];
        carry_nxt = prod[PROD_W-1:8];
      end
      CM_RIPPLE: begin
        prod      = PROD_W'(byte_r) + PROD_W'(carry_in);
        byte_nxt  = prod[7:0];
        carry_nxt = prod[PROD_W-1:8];
      end
      CM_SHIFT: begin
        byte_nxt  = shift_in;
        carry_nxt = '0;
      end
      CM_CLEAR: begin
        byte_nxt  = '0;
        carry_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r  <= '0;
      carry_r <= '0;
    end else begin
      byte_r  <= byte_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign byte_out  = byte_r;
  assign carry_out = carry_r;

endmodule

`default_nettype wire

// ===== rtl/base58_string_decoder_unit.sv =====
// Top level of the Base58 string decoder: scan control, cell row, result register.
// Depends on b58d_pkg and b58d_cell.
`timescale 1ns / 1ps
`default_nettype none

// Base58 (common alphabet) string decoder. Characters arrive one per input
// item, in_tlast on the final one. Leading whitespace is skipped, leading '1's
// count as zero bytes, digits fold into a big-endian accumulator held in a row
// of ACC_BYTES byte cells. A digit multiplies every cell by 58 at once;
// the carries then ripple one cell per cycle until none is left, so a digit
// holds the input until its carries have settled, depending on how far they
// travel. Whitespace, '1's and characters after an error hold the input only
// if final. On the final character the row shifts toward its top to drop
// leading zero bytes; then a zero byte per leading '1' and the value stream
// out, held by any stall on the result side. A failed or empty string gives
// a single status result. The result register lets the next string start
// while the last result still waits. No clearing pass after reset.
module base58_string_decoder_unit
  import b58d_pkg::*;
#(
  parameter int MAX_CHARS = 64,  // 1..64
  parameter int ACC_BYTES = 47   // 1..47
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tlast,   // end_of_string
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] byte_value, [9:8] status, rest zero
  output logic             out_tuser,  // has_byte
  output logic             out_tlast   // last
);

  localparam int REM_W = $clog2(ACC_BYTES + 1);
  localparam logic [REM_W-1:0] REM_INIT = REM_W'(ACC_BYTES);
  localparam logic [CNT_W-1:0] MAX_C    = CNT_W'(MAX_CHARS);
  localparam logic [CNT_W-1:0] ONES_SAT = {CNT_W{1'b1}};

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RIPPLE = 3'd1;
  localparam logic [2:0] S_SKIP   = 3'd2;
  localparam logic [2:0] S_ONES   = 3'd3;
  localparam logic [2:0] S_BYTES  = 3'd4;
  localparam logic [2:0] S_STAT   = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] tot_r, tot_nxt;
  logic [CNT_W-1:0] ones_r, ones_nxt;
  logic [1:0]       ph_r, ph_nxt;
  logic [1:0]       err_r, err_nxt;
  logic             pend_r, pend_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;

  logic             out_tvalid_r;
  logic [7:0]       out_byte_r;
  logic             out_has_r, out_last_r;
  logic [1:0]       out_stat_r;

  logic             in_acc, out_free;
  logic             emit, emit_has, emit_last, done;
  logic [7:0]       emit_byte;
  logic [1:0]       emit_stat;

  cell_mode_t       mode;
  logic [7:0]         acc_byte  [ACC_BYTES];
  logic [CARRY_W-1:0] acc_carry [ACC_BYTES];
  logic             any_carry, acc_any;

  // Scan results for the character on the input
  logic [CNT_W-1:0] tot_inc, ones_scan;
  logic [1:0]       ph_scan, err_scan;
  logic             start_add, c_blank;
  logic [DIG_W:0]   dig_v;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Cell row: index 0 holds the most significant byte
  for (genvar i = 0; i < ACC_BYTES; i++) begin : g_cell
    logic [DIG_W-1:0]   dig_i;
    logic [CARRY_W-1:0] cin_i;
    logic [7:0]         sin_i;
    if (i == ACC_BYTES - 1) begin : g_lsb
      assign dig_i = dig_v[DIG_W-1:0];
      assign cin_i = '0;
      assign sin_i = '0;
    end else begin : g_mid
      assign dig_i = '0;
      assign cin_i = acc_carry[i+1];
      assign sin_i = acc_byte[i+1];
    end
    b58d_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .mode      (mode),
      .digit_in  (dig_i),
      .carry_in  (cin_i),
      .shift_in  (sin_i),
      .byte_out  (acc_byte[i]),
      .carry_out (acc_carry[i])
    );
  end

  always_comb begin
    any_carry = 1'b0;
    acc_any   = 1'b0;
    for (int i = 0; i < ACC_BYTES; i++) begin
      any_carry = any_carry | (|acc_carry[i]);
      acc_any   = acc_any | (|acc_byte[i]);
    end
  end

  // Character classification; a digit starts a multiply-add on the row
  always_comb begin
    c_blank   = is_blank(in_tdata);
    dig_v     = digit_of(in_tdata);
    tot_inc   = (tot_r <= MAX_C) ? tot_r + 1'b1 : tot_r;
    ones_scan = ones_r;
    ph_scan   = ph_r;
    err_scan  = err_r;
    start_add = 1'b0;
    if (tot_inc > MAX_C) begin
      err_scan = ST_LONG;
    end else if (err_r == ST_OK) begin
      if (ph_r == PH_LEAD && c_blank) begin
        // skip leading whitespace
      end else if ((ph_r == PH_LEAD || ph_r == PH_ONES) && in_tdata == CH_ONE) begin
        ph_scan = PH_ONES;
        if (ones_r != ONES_SAT) ones_scan = ones_r + 1'b1;
      end else if (ph_r == PH_TRAIL) begin
        if (!c_blank) err_scan = ST_TRAIL;
      end else if (c_blank) begin
        ph_scan = PH_TRAIL;
      end else begin
        ph_scan = PH_DIG;
        if (dig_v[DIG_W]) start_add = 1'b1;
        else              err_scan  = ST_BAD_CHAR;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    tot_nxt   = tot_r;
    ones_nxt  = ones_r;
    ph_nxt    = ph_r;
    err_nxt   = err_r;
    pend_nxt  = pend_r;
    rem_nxt   = rem_r;
    mode      = CM_HOLD;
    emit      = 1'b0;
    emit_byte = '0;
    emit_has  = 1'b0;
    emit_last = 1'b0;
    emit_stat = ST_OK;
    done      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          tot_nxt  = tot_inc;
          ones_nxt = ones_scan;
          ph_nxt   = ph_scan;
          err_nxt  = err_scan;
          if (start_add) begin
            mode      = CM_MUL;
            state_nxt = S_RIPPLE;
            pend_nxt  = in_tlast;
          end else if (in_tlast) begin
            state_nxt = S_SKIP;
            rem_nxt   = REM_INIT;
          end
        end
      end
      S_RIPPLE: begin
        // advance carries until every cell has settled
        if (any_carry) begin
          mode = CM_RIPPLE;
        end else if (pend_r) begin
          state_nxt = S_SKIP;
          rem_nxt   = REM_INIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SKIP: begin
        // drop leading zero bytes of the accumulator
        if (err_r != ST_OK) begin
          state_nxt = S_STAT;
        end else if (rem_r == '0 || acc_byte[0] != 8'd0) begin
          state_nxt = (ones_r == '0 && rem_r == '0) ? S_STAT : S_ONES;
        end else begin
          mode    = CM_SHIFT;
          rem_nxt = rem_r - 1'b1;
        end
      end
      S_ONES: begin
        if (ones_r == '0) begin
          state_nxt = S_BYTES;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_has  = 1'b1;
          emit_last = (ones_r == CNT_W'(1)) && (rem_r == '0);
          ones_nxt  = ones_r - 1'b1;
          done      = emit_last;
        end
      end
      S_BYTES: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = acc_byte[0];
          emit_has  = 1'b1;
          emit_last = (rem_r == REM_W'(1));
          mode      = CM_SHIFT;
          rem_nxt   = rem_r - 1'b1;
          done      = emit_last;
        end
      end
      S_STAT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          emit_stat = err_r;
          done      = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // End of string: clear the row and the per-string scan state
    if (done) begin
      mode      = CM_CLEAR;
      state_nxt = S_IDLE;
      tot_nxt   = '0;
      ones_nxt  = '0;
      ph_nxt    = PH_LEAD;
      err_nxt   = ST_OK;
      pend_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      tot_r   <= '0;
      ones_r  <= '0;
      ph_r    <= PH_LEAD;
      err_r   <= ST_OK;
      pend_r  <= 1'b0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      tot_r   <= tot_nxt;
      ones_r  <= ones_nxt;
      ph_r    <= ph_nxt;
      err_r   <= err_nxt;
      pend_r  <= pend_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // Result register: load on emit, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (emit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= emit_byte;
      out_has_r  <= emit_has;
      out_last_r <= emit_last;
      out_stat_r <= emit_stat;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b0, out_stat_r, out_byte_r};
  assign out_tuser  = out_has_r;
  assign out_tlast  = out_last_r;

  // A result without a byte is always the only, hence final, result
  a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("status result without last");

  // An error status never comes with a byte
  a_err_nobyte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[9:8] != ST_OK) |-> !out_tuser)
    else $error("error status carries a byte");

  // Finishing a string leaves the row and the character counters clear
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> (!acc_any && !any_carry && ones_r == '0 && err_r == ST_OK && tot_r == '0))
    else $error("per-string state not cleared");

  // Results only come out of the emission states
  a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |->
      ($past(state_r) == S_ONES || $past(state_r) == S_BYTES || $past(state_r) == S_STAT))
    else $error("result raised outside emission");

endmodule

`default_nettype wire
